// ===== rtl/bba_pkg.sv =====
`timescale 1ns / 1ps
// bba_pkg: shared types and codes of the bitmap block allocator
// command and response word layouts, command, status and register codes
// no dependencies
package bba_pkg;

	localparam int BLK_W  = 12;
	localparam int CNT_W  = 13;
	localparam int CMD_W  = 3;
	localparam int STAT_W = 2;
	localparam int CFG_W  = 13;

	localparam logic [CNT_W-1:0] COUNT_MAX   = 13'd8191;
	localparam logic [CFG_W-1:0] TOTAL_RESET = 13'd4096;
	localparam logic [CFG_W-1:0] META_RESET  = 13'd0;

	// command codes
	localparam logic [CMD_W-1:0] CMD_READ   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SET    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ALLOC  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_FREE   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_FORMAT = 3'd5;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NO_FREE  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd2;
	localparam logic [STAT_W-1:0] STAT_WAS_FREE = 2'd3;

	// configuration register indexes
	localparam logic REG_TOTAL = 1'b0;
	localparam logic REG_META  = 1'b1;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [BLK_W-1:0] block_number;
	} cmd_t;

	typedef struct packed {
		logic [BLK_W-1:0]  result_block;
		logic              bit_value;
		logic [STAT_W-1:0] status;
		logic [CNT_W-1:0]  free_blocks;
	} rsp_t;

endpackage

// ===== rtl/bitmap_block_allocator.sv =====
`timescale 1ns / 1ps
// bitmap_block_allocator: first-fit block allocator over a used/free bitmap
// bitmap words in a synchronous RAM, per-word full summary in flops
// depends on bba_pkg
//
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd_data) takes one command word: read,
//   set, clear, allocate, free or format, with a block number.
//   rsp channel (rsp_valid/rsp_ready/rsp_data) returns exactly one response
//   word per command, in order: block, read bit, status and free count.
//   cfg port (cfg_we/cfg_index/cfg_data) writes total_blocks (index 0) and
//   metadata_blocks (index 1); write only while no command is in flight.
// Flow: a command passes accept (summary priority encode picks the
//   first non-full word), RAM read, then modify/write-back and response
//   register load. One command is in flight at a time, set by the read-modify-write
//   on the single RAM port: a new command is taken only after the last one is through.
// Reset: all blocks free, free count at its maximum, no RAM clearing pass;
//   per-word valid flops make unwritten words read as the last format image.
// Stall: the response register holds while rsp_ready is low; a new command is
//   still accepted and waits in the modify stage until the register drains.
module bitmap_block_allocator #(
	parameter int MAX_BLOCKS = 4096,
	parameter int WORD_BITS  = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  bba_pkg::cmd_t         cmd_data,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output bba_pkg::rsp_t         rsp_data,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [bba_pkg::CFG_W-1:0] cfg_data
);
	import bba_pkg::*;

	localparam int NWORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int LW     = $clog2(WORD_BITS);
	localparam int WIW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int MW     = $clog2(MAX_BLOCKS + 1);
	localparam int TW     = (MW > CFG_W) ? MW : CFG_W;
	localparam logic [TW-1:0] MAX_T = TW'(MAX_BLOCKS);
	localparam logic [CNT_W-1:0] COUNT_RESET =
		(MAX_BLOCKS < 8191) ? CNT_W'(MAX_BLOCKS) : COUNT_MAX;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_MOD  = 2'd2;

	logic [1:0]           state_q;
	logic [CFG_W-1:0]     total_q;
	logic [CFG_W-1:0]     meta_q;
	logic [CNT_W-1:0]     free_count_q;
	logic [NWORDS-1:0]    summary_q;
	logic [NWORDS-1:0]    word_valid_q;
	logic [TW-1:0]        fmt_nmeta_q;
	logic [CMD_W-1:0]     cmd_q;
	logic [TW-1:0]        blk_q;
	logic                 in_range_q;
	logic [WIW-1:0]       addr_q;
	logic                 alloc_any_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	logic [WORD_BITS-1:0] mem [NWORDS];
	logic [WORD_BITS-1:0] rd_data_q;

	logic [TW-1:0]        usable;
	logic [TW-1:0]        nmeta;
	logic [TW-1:0]        fmt_diff;
	logic [CNT_W-1:0]     fmt_count;
	logic [TW-1:0]        blk_ext;
	logic [WIW-1:0]       first_free;
	logic                 first_any;
	logic [TW-1:0]        fmt_words;
	logic [TW-1:0]        addr_ext;
	logic [WORD_BITS-1:0] fmt_pattern;
	logic [WORD_BITS-1:0] word_eff;
	logic [LW-1:0]        bit_sel;
	logic [LW-1:0]        zero_idx;
	logic                 zero_any;
	logic [TW-1:0]        found_blk;
	logic                 alloc_ok;
	logic [WORD_BITS-1:0] new_word;
	logic                 wr_en;
	logic                 do_format;
	logic [CNT_W-1:0]     count_next;
	rsp_t                 rsp_next;
	logic                 accept;
	logic                 mod_go;

	assign cmd_ready = (state_q == S_IDLE);
	assign accept    = cmd_valid && cmd_ready;
	assign mod_go    = (state_q == S_MOD) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// usable size and format figures
	always_comb begin
		usable    = (TW'(total_q) < MAX_T) ? TW'(total_q) : MAX_T;
		nmeta     = (TW'(meta_q) < usable) ? TW'(meta_q) : usable;
		fmt_diff  = usable - nmeta;
		fmt_count = (fmt_diff > TW'(COUNT_MAX)) ? COUNT_MAX : fmt_diff[CNT_W-1:0];
	end

	assign blk_ext = TW'(cmd_data.block_number);

	// first word that still has a free bit
	always_comb begin
		first_free = '0;
		first_any  = 1'b0;
		for (int i = NWORDS - 1; i >= 0; i--) begin
			if (!summary_q[i]) begin
				first_free = WIW'(i);
				first_any  = 1'b1;
			end
		end
	end

	// a word not written since the last format reads as the format image
	always_comb begin
		fmt_words = fmt_nmeta_q >> LW;
		addr_ext  = TW'(addr_q);
		if (addr_ext < fmt_words) begin
			fmt_pattern = '1;
		end else if (addr_ext == fmt_words) begin
			fmt_pattern = (WORD_BITS'(1) << fmt_nmeta_q[LW-1:0]) - WORD_BITS'(1);
		end else begin
			fmt_pattern = '0;
		end
		word_eff = word_valid_q[addr_q] ? rd_data_q : fmt_pattern;
	end

	// lowest free bit in the word
	always_comb begin
		zero_idx = '0;
		zero_any = 1'b0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!word_eff[i]) begin
				zero_idx = LW'(i);
				zero_any = 1'b1;
			end
		end
	end

	assign bit_sel   = blk_q[LW-1:0];
	assign found_blk = (TW'(addr_q) << LW) | TW'(zero_idx);
	assign alloc_ok  = (free_count_q != '0) && alloc_any_q && zero_any && (found_blk < usable);

	always_comb begin
		new_word              = word_eff;
		wr_en                 = 1'b0;
		do_format             = 1'b0;
		count_next            = free_count_q;
		rsp_next.result_block = blk_q[BLK_W-1:0];
		rsp_next.bit_value    = 1'b0;
		rsp_next.status       = STAT_OK;
		case (cmd_q)
			CMD_READ: begin
				if (in_range_q) begin
					rsp_next.bit_value = word_eff[bit_sel];
				end else begin
					rsp_next.status = STAT_RANGE;
				end
			end
			CMD_SET, CMD_CLEAR: begin
				if (in_range_q) begin
					new_word[bit_sel] = (cmd_q == CMD_SET);
					wr_en             = 1'b1;
				end else begin
					rsp_next.status = STAT_RANGE;
				end
			end
			CMD_ALLOC: begin
				if (alloc_ok) begin
					new_word[zero_idx]    = 1'b1;
					wr_en                 = 1'b1;
					count_next            = free_count_q - CNT_W'(1);
					rsp_next.result_block = found_blk[BLK_W-1:0];
				end else begin
					rsp_next.status = STAT_NO_FREE;
				end
			end
			CMD_FREE: begin
				if (!in_range_q) begin
					rsp_next.status = STAT_RANGE;
				end else if (!word_eff[bit_sel]) begin
					rsp_next.status = STAT_WAS_FREE;
				end else begin
					new_word[bit_sel] = 1'b0;
					wr_en             = 1'b1;
					if (free_count_q != COUNT_MAX) begin
						count_next = free_count_q + CNT_W'(1);
					end
				end
			end
			CMD_FORMAT: begin
				do_format  = 1'b1;
				count_next = fmt_count;
			end
			default: begin
			end
		endcase
		rsp_next.free_blocks = count_next;
	end

	// bitmap RAM
	always_ff @(posedge clk) begin
		if (mod_go && wr_en) begin
			mem[addr_q] <= new_word;
		end
		if (state_q == S_READ) begin
			rd_data_q <= mem[addr_q];
		end
	end

	// command capture and response register, payload only
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q       <= cmd_data.command;
			blk_q       <= blk_ext;
			in_range_q  <= blk_ext < usable;
			alloc_any_q <= first_any;
			addr_q      <= (cmd_data.command == CMD_ALLOC) ? first_free : blk_ext[LW +: WIW];
		end
		if (mod_go) begin
			rsp_q <= rsp_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			total_q      <= TOTAL_RESET;
			meta_q       <= META_RESET;
			free_count_q <= COUNT_RESET;
			summary_q    <= '0;
			word_valid_q <= '0;
			fmt_nmeta_q  <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TOTAL: total_q <= cfg_data;
					REG_META:  meta_q  <= cfg_data;
					default: begin
					end
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_MOD;
				end
				S_MOD: begin
					if (mod_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (mod_go) begin
				rsp_valid_q  <= 1'b1;
				free_count_q <= count_next;
				if (do_format) begin
					word_valid_q <= '0;
					fmt_nmeta_q  <= nmeta;
					for (int i = 0; i < NWORDS; i++) begin
						summary_q[i] <= TW'(i) < (nmeta >> LW);
					end
				end else if (wr_en) begin
					word_valid_q[addr_q] <= 1'b1;
					summary_q[addr_q]    <= &new_word;
				end
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule
